[rtl/track_measurement_gating_score_unit_assert.svh]
// Assertion macros used by the gating score unit back end.
`ifndef TRACK_MEASUREMENT_GATING_SCORE_UNIT_ASSERT_SVH
`define TRACK_MEASUREMENT_GATING_SCORE_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define TMGS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define TMGS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tmgs_pkg.sv]
// Types, constants and step functions of the gating score unit.
package tmgs_pkg;

	localparam int TDATA_IN_W  = 232;
	localparam int TUSER_IN_W  = 1;
	localparam int TDATA_OUT_W = 24;
	localparam int STATUS_W    = 3;
	localparam int COORD_W     = 32;
	localparam int GATE_W      = 16;
	localparam int AREA_W      = 24;
	localparam int SCORE_W     = 17;
	localparam int RULE_W      = GATE_W + 1;
	localparam int BOUND_W     = 2 * AREA_W;
	localparam int SQR_W       = 2 * GATE_W;
	localparam int SUM_W       = 34;
	localparam int ROOT_W      = 17;
	localparam int REM_W       = 18;
	localparam int SQRT_STEPS  = 17;
	localparam int DIV_STEPS   = 17;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [SCORE_W-1:0] SCORE_MAX = 17'd65536;
	localparam logic [ROOT_W-1:0]  DIST_MAX  = 17'd92682;

	localparam logic MODE_SCORE = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_SCORED   = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_BARRED   = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_GATED    = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_AREA_OUT = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_WRITTEN  = 3'd4;

	// Classified item handed from the front to the back
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [GATE_W-1:0]   dx;
		logic [GATE_W-1:0]   dy;
		logic [GATE_W-1:0]   gate;
		logic                area_out;
	} queue_entry_t;

	// What rides along the back pipeline beside the arithmetic
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [GATE_W-1:0]   gate;
		logic                area_out;
	} carry_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_state_t;

	typedef struct packed {
		logic [SCORE_W-1:0] rem;
		logic [SCORE_W-1:0] quo;
	} div_state_t;

	// One digit of the bit-by-bit integer square root
	function automatic sqrt_state_t sqrt_step(sqrt_state_t cur, logic [1:0] pair);
		logic [REM_W+1:0] acc;
		logic [REM_W+1:0] trial;
		sqrt_state_t      nxt;
		acc   = {cur.rem, pair};
		trial = {1'b0, cur.root, 2'b01};
		if (acc >= trial) begin
			nxt.rem  = REM_W'(acc - trial);
			nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = REM_W'(acc);
			nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

	// One quotient bit of the restoring divide by the gate
	function automatic div_state_t div_step(div_state_t cur, logic [GATE_W-1:0] gate);
		logic [SCORE_W-1:0] red;
		logic               ge;
		div_state_t         nxt;
		ge      = cur.rem >= {1'b0, gate};
		red     = ge ? (cur.rem - {1'b0, gate}) : cur.rem;
		nxt.rem = {red[SCORE_W-2:0], 1'b0};
		nxt.quo = {cur.quo[SCORE_W-2:0], ge};
		return nxt;
	endfunction

endpackage

[rtl/tmgs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tmgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/tmgs_front.sv]
// Front end: accepts items, owns the class tables and classifies each item.
module tmgs_front #(
	parameter int CLASS_CODES = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tmgs_pkg::TDATA_IN_W-1:0]  s_tdata,
	input  logic [tmgs_pkg::TUSER_IN_W-1:0]  s_tuser,
	output logic                             push,
	output tmgs_pkg::queue_entry_t           push_entry,
	input  logic                             q_ready
);
	import tmgs_pkg::*;

	localparam int DEPTH = CLASS_CODES * CLASS_CODES;
	localparam int AW    = $clog2(DEPTH);

	logic [4:0]           tc, mc;
	logic [COORD_W-1:0]   tx, ty, mx, my;
	logic [AREA_W-1:0]    area;
	logic                 accept, is_write, in_range;
	logic [15:0]          idx_full;
	logic [AW-1:0]        idx;
	logic signed [COORD_W:0] dxs, dys;
	logic [COORD_W-1:0]   dx_abs, dy_abs;
	logic [RULE_W-1:0]    rule_wdata, rule_rd;
	logic [BOUND_W-1:0]   bound_wdata, bound_rd;

	logic                 s1_valid_q;
	logic                 write_s1, range_s1;
	logic [COORD_W-1:0]   dx_s1, dy_s1;
	logic [AREA_W-1:0]    area_s1;

	logic [GATE_W-1:0]    gate;
	logic [AREA_W-1:0]    amin, amax;

	assign tc          = s_tdata[4:0];
	assign mc          = s_tdata[9:5];
	assign tx          = s_tdata[41:10];
	assign ty          = s_tdata[73:42];
	assign mx          = s_tdata[105:74];
	assign my          = s_tdata[137:106];
	assign area        = s_tdata[161:138];
	assign rule_wdata  = {s_tdata[162], s_tdata[178:163]};
	assign bound_wdata = {s_tdata[202:179], s_tdata[226:203]};

	assign s_tready = !s1_valid_q || q_ready;
	assign accept   = s_tvalid && s_tready;
	assign is_write = (s_tuser[0] == MODE_WRITE);
	assign in_range = (32'(tc) < CLASS_CODES) && (32'(mc) < CLASS_CODES);
	assign idx_full = 16'(tc) * 16'(CLASS_CODES) + 16'(mc);
	assign idx      = idx_full[AW-1:0];

	assign dxs    = $signed({tx[COORD_W-1], tx}) - $signed({mx[COORD_W-1], mx});
	assign dys    = $signed({ty[COORD_W-1], ty}) - $signed({my[COORD_W-1], my});
	assign dx_abs = dxs[COORD_W] ? COORD_W'(-dxs) : dxs[COORD_W-1:0];
	assign dy_abs = dys[COORD_W] ? COORD_W'(-dys) : dys[COORD_W-1:0];

	// Read on every accept; read data holds while the item waits in s1
	tmgs_ram #(.WIDTH(RULE_W), .DEPTH(DEPTH)) u_rule_ram (
		.clk   (clk),
		.we    (accept && is_write && in_range),
		.waddr (idx),
		.wdata (rule_wdata),
		.re    (accept),
		.raddr (idx),
		.rdata (rule_rd)
	);

	tmgs_ram #(.WIDTH(BOUND_W), .DEPTH(DEPTH)) u_bound_ram (
		.clk   (clk),
		.we    (accept && is_write && in_range),
		.waddr (idx),
		.wdata (bound_wdata),
		.re    (accept),
		.raddr (idx),
		.rdata (bound_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			write_s1 <= is_write;
			range_s1 <= in_range;
			dx_s1    <= dx_abs;
			dy_s1    <= dy_abs;
			area_s1  <= area;
		end
	end

	assign gate = rule_rd[GATE_W-1:0];
	assign amin = bound_rd[BOUND_W-1:AREA_W];
	assign amax = bound_rd[AREA_W-1:0];

	always_comb begin
		push_entry.dx       = dx_s1[GATE_W-1:0];
		push_entry.dy       = dy_s1[GATE_W-1:0];
		push_entry.gate     = gate;
		push_entry.area_out = (area_s1 < amin) || (area_s1 > amax);
		if (write_s1) begin
			push_entry.status = STATUS_WRITTEN;
		end else if (!range_s1 || !rule_rd[GATE_W]) begin
			push_entry.status = STATUS_BARRED;
		end else if ((gate == '0) || (dx_s1 > COORD_W'(gate)) || (dy_s1 > COORD_W'(gate))) begin
			push_entry.status = STATUS_GATED;
		end else begin
			push_entry.status = STATUS_SCORED;
		end
	end

	assign push = s1_valid_q && q_ready;

endmodule

[rtl/tmgs_queue.sv]
// Short FIFO of classified items between the front and the back.
module tmgs_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tmgs_pkg::queue_entry_t push_entry,
	output logic                   q_ready,
	input  logic                   pop,
	output logic                   q_valid,
	output tmgs_pkg::queue_entry_t q_entry
);
	import tmgs_pkg::*;

	queue_entry_t       slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wptr_q, rptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign q_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign q_valid = count_q != '0;
	assign q_entry = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end

endmodule

[rtl/tmgs_back.sv]
// Back end: squares, square root, gate and area checks, score divide.
module tmgs_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	input  tmgs_pkg::queue_entry_t           q_entry,
	output logic                             pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tmgs_pkg::TDATA_OUT_W-1:0] m_tdata,
	output logic [tmgs_pkg::STATUS_W-1:0]    m_tuser
);
	import tmgs_pkg::*;
	`include "track_measurement_gating_score_unit_assert.svh"

	logic en;

	logic             v_s1;
	carry_t           carry_s1;
	logic [SQR_W-1:0] dx2_s1, dy2_s1;

	logic        sq_v_q     [SQRT_STEPS+1];
	carry_t      sq_carry_q [SQRT_STEPS+1];
	logic [SUM_W-1:0] sq_val_q [SQRT_STEPS+1];
	sqrt_state_t sq_st_q    [SQRT_STEPS+1];

	logic        dv_v_q      [DIV_STEPS+1];
	logic [STATUS_W-1:0] dv_status_q [DIV_STEPS+1];
	logic [GATE_W-1:0]   dv_gate_q   [DIV_STEPS+1];
	div_state_t  dv_st_q     [DIV_STEPS+1];

	logic [ROOT_W-1:0]   root_dist;
	carry_t              ck_carry;
	logic [STATUS_W-1:0] ck_status;
	logic [GATE_W-1:0]   ck_diff;

	// The whole back pipeline advances together
	assign en  = !m_tvalid || m_tready;
	assign pop = en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			sq_v_q[0] <= 1'b0;
			dv_v_q[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			sq_v_q[0] <= v_s1;
			dv_v_q[0] <= sq_v_q[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s1.status   <= q_entry.status;
			carry_s1.gate     <= q_entry.gate;
			carry_s1.area_out <= q_entry.area_out;
			dx2_s1 <= q_entry.dx * q_entry.dx;
			dy2_s1 <= q_entry.dy * q_entry.dy;
			sq_carry_q[0] <= carry_s1;
			sq_val_q[0]   <= SUM_W'(dx2_s1) + SUM_W'(dy2_s1);
			sq_st_q[0]    <= '0;
			dv_status_q[0] <= ck_status;
			dv_gate_q[0]   <= ck_carry.gate;
			dv_st_q[0].rem <= {1'b0, ck_diff};
			dv_st_q[0].quo <= '0;
		end
	end

	for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
		localparam int P = SQRT_STEPS - k;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_q[k] <= 1'b0;
			end else if (en) begin
				sq_v_q[k] <= sq_v_q[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_carry_q[k] <= sq_carry_q[k-1];
				sq_val_q[k]   <= sq_val_q[k-1];
				sq_st_q[k]    <= sqrt_step(sq_st_q[k-1], sq_val_q[k-1][2*P+1 -: 2]);
			end
		end
	end

	// Distance gate first, then the area bounds
	assign root_dist = sq_st_q[SQRT_STEPS].root;
	assign ck_carry  = sq_carry_q[SQRT_STEPS];
	assign ck_diff   = ck_carry.gate - root_dist[GATE_W-1:0];

	always_comb begin
		ck_status = ck_carry.status;
		if (ck_carry.status == STATUS_SCORED) begin
			if (root_dist > ROOT_W'(ck_carry.gate)) begin
				ck_status = STATUS_GATED;
			end else if (ck_carry.area_out) begin
				ck_status = STATUS_AREA_OUT;
			end
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_q[k] <= 1'b0;
			end else if (en) begin
				dv_v_q[k] <= dv_v_q[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_status_q[k] <= dv_status_q[k-1];
				dv_gate_q[k]   <= dv_gate_q[k-1];
				dv_st_q[k]     <= div_step(dv_st_q[k-1], dv_gate_q[k-1]);
			end
		end
	end

	assign m_tvalid = dv_v_q[DIV_STEPS];
	assign m_tuser  = dv_status_q[DIV_STEPS];
	assign m_tdata  = TDATA_OUT_W'((dv_status_q[DIV_STEPS] == STATUS_SCORED) ?
		dv_st_q[DIV_STEPS].quo : '0);

	`TMGS_ASSERT_IMP(a_gated_scores_zero, m_tvalid && (m_tuser != STATUS_SCORED), m_tdata == '0, "nonzero score on a gated item")
	`TMGS_ASSERT_IMP(a_score_in_range, m_tvalid, m_tdata[SCORE_W-1:0] <= SCORE_MAX, "score above one")
	`TMGS_ASSERT_IMP(a_dist_bounded, sq_v_q[SQRT_STEPS] && (ck_carry.status == STATUS_SCORED), root_dist <= DIST_MAX, "distance beyond per-axis gate bound")
	`TMGS_ASSERT_NEXT(a_write_passes, pop && (q_entry.status == STATUS_WRITTEN), v_s1 && (carry_s1.status == STATUS_WRITTEN), "write item lost entering back end")

endmodule

[rtl/track_measurement_gating_score_unit.sv]
// Top level of the gated distance association score unit.
//   channel  dir  tdata                                  tuser
//   s_       in   class pair, positions, area, entry     mode
//   m_       out  score                                  status
// One item enters per cycle and one result leaves per cycle when nothing stalls.
// Stages: 1 table-read stage, 1 queue slot,
// 37 back stages (squares, sum, 17 root digits, checks, 17 quotient bits).
// Reset clears only control state; table entries are undefined until written.
// A stall at m_ freezes the back end; the 4-entry queue then fills before s_tready drops.
module track_measurement_gating_score_unit #(
	parameter int CLASS_CODES = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// tracker_class, measure_class, tracker_x, tracker_y, meas_x, meas_y, meas_area,
	// entry_allowed, entry_gate_dist, entry_min_area, entry_max_area, zero pad
	input  logic [tmgs_pkg::TDATA_IN_W-1:0]  s_tdata,
	// mode
	input  logic [tmgs_pkg::TUSER_IN_W-1:0]  s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// score, zero pad
	output logic [tmgs_pkg::TDATA_OUT_W-1:0] m_tdata,
	// status
	output logic [tmgs_pkg::STATUS_W-1:0]    m_tuser
);
	import tmgs_pkg::*;

	logic         push, q_ready, pop, q_valid;
	queue_entry_t push_entry, q_entry;

	tmgs_front #(.CLASS_CODES(CLASS_CODES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready)
	);

	tmgs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready),
		.pop        (pop),
		.q_valid    (q_valid),
		.q_entry    (q_entry)
	);

	tmgs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

[verif/track_measurement_gating_score_unit_tb.sv]
// Self-checking testbench for the gated distance association score unit.
module track_measurement_gating_score_unit_tb;
	import tmgs_pkg::*;

	localparam int NCLS       = 32;
	localparam int NENT       = NCLS * NCLS;
	localparam int RAND_ITEMS = 760;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic              mode;
		logic [4:0]        tc;
		logic [4:0]        mc;
		logic [31:0]       tx;
		logic [31:0]       ty;
		logic [31:0]       mx;
		logic [31:0]       my;
		logic [23:0]       area;
		logic              allowed;
		logic [15:0]       gate;
		logic [23:0]       amin;
		logic [23:0]       amax;
	} pair_item_t;

	typedef struct {
		logic [SCORE_W-1:0]  score;
		logic [STATUS_W-1:0] status;
	} score_result_t;

	class score_board;
		logic [RULE_W-1:0]  rule_tab [NENT];
		logic [BOUND_W-1:0] bound_tab[NENT];
		score_result_t      pending[$];
		int                 errors;
		int                 n_checked;
		int                 n_status[5];

		function automatic longint unsigned root_floor(longint unsigned v);
			longint unsigned r;
			r = 0;
			for (int b = 17; b >= 0; b--) begin
				if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
					r = r | (64'd1 << b);
			end
			return r;
		endfunction

		function automatic longint unsigned span(logic [31:0] a, logic [31:0] b);
			longint d;
			d = longint'($signed(a)) - longint'($signed(b));
			return (d < 0) ? -d : d;
		endfunction

		// Update the tables and queue the expected result of one accepted item
		function void note_item(pair_item_t it);
			score_result_t   r;
			int              idx;
			longint unsigned g, dx, dy, d;
			idx = int'({it.tc, it.mc});
			r.score = '0;
			if (it.mode == MODE_WRITE) begin
				rule_tab[idx]  = {it.allowed, it.gate};
				bound_tab[idx] = {it.amin, it.amax};
				r.status = STATUS_WRITTEN;
			end else if (!rule_tab[idx][GATE_W]) begin
				r.status = STATUS_BARRED;
			end else begin
				g  = rule_tab[idx][GATE_W-1:0];
				dx = span(it.tx, it.mx);
				dy = span(it.ty, it.my);
				d  = (dx > g || dy > g) ? g + 1 : root_floor(dx * dx + dy * dy);
				if (g == 0 || d > g)
					r.status = STATUS_GATED;
				else if (it.area < bound_tab[idx][47:24] || it.area > bound_tab[idx][23:0])
					r.status = STATUS_AREA_OUT;
				else begin
					r.status = STATUS_SCORED;
					r.score  = SCORE_W'(((g - d) << 16) / g);
				end
			end
			pending = {pending, r};
		endfunction

		function void check_result(logic [SCORE_W-1:0] score, logic [STATUS_W-1:0] status);
			score_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result: score %0d status %0d", score, status);
				errors++;
				return;
			end
			e = pending.pop_front();
			n_checked++;
			if (e.status <= STATUS_WRITTEN)
				n_status[e.status]++;
			if (status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, status);
				errors++;
			end
			if (score !== e.score) begin
				$error("score: expected %0d, actual %0d", e.score, score);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata;
	logic [TUSER_IN_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic [STATUS_W-1:0]    m_tuser;

	score_board sb;
	int         idle_cycles;
	int         burst_left;
	int         n_sent;

	track_measurement_gating_score_unit #(.CLASS_CODES(NCLS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Present one item at the falling edge, hold it until accepted
	task automatic send_item(pair_item_t it);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
		end
		burst_left--;
		s_tdata  = {5'd0, it.amax, it.amin, it.gate, it.allowed, it.area,
			it.my, it.mx, it.ty, it.tx, it.mc, it.tc};
		s_tuser  = it.mode;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_item(it);
		n_sent++;
		@(negedge clk);
	endtask

	function automatic pair_item_t write_item(logic [4:0] tc, logic [4:0] mc, logic allowed,
			logic [15:0] gate, logic [23:0] amin, logic [23:0] amax);
		pair_item_t it;
		it = '{default: '0};
		it.mode = MODE_WRITE; it.tc = tc; it.mc = mc; it.allowed = allowed;
		it.gate = gate; it.amin = amin; it.amax = amax;
		it.tx = $urandom; it.ty = $urandom; it.mx = $urandom; it.my = $urandom;
		it.area = 24'($urandom);
		return it;
	endfunction

	function automatic pair_item_t rand_entry(logic [4:0] tc, logic [4:0] mc);
		logic [15:0] g;
		logic [23:0] a, b;
		int          k;
		k = $urandom_range(0, 9);
		g = (k == 0) ? 16'd0 : (k == 1) ? 16'hFFFF : (k == 2) ? 16'($urandom_range(1, 16))
			: 16'($urandom);
		a = 24'($urandom); b = 24'($urandom);
		k = $urandom_range(0, 19);
		if (k == 0)
			return write_item(tc, mc, $urandom_range(0, 6) != 0, g, 24'hFFFFFF, 24'd0);
		if (k == 1)
			return write_item(tc, mc, $urandom_range(0, 6) != 0, g, 24'd0, 24'hFFFFFF);
		if (a > b)
			return write_item(tc, mc, $urandom_range(0, 6) != 0, g, b, a);
		return write_item(tc, mc, $urandom_range(0, 6) != 0, g, a, b);
	endfunction

	function automatic pair_item_t score_item(logic [4:0] tc, logic [4:0] mc, logic [31:0] tx,
			logic [31:0] ty, logic [31:0] mx, logic [31:0] my, logic [23:0] area);
		pair_item_t it;
		it = '{default: '0};
		it.mode = MODE_SCORE; it.tc = tc; it.mc = mc;
		it.tx = tx; it.ty = ty; it.mx = mx; it.my = my; it.area = area;
		it.allowed = 1'($urandom); it.gate = 16'($urandom);
		it.amin = 24'($urandom); it.amax = 24'($urandom);
		return it;
	endfunction

	// Aim the measurement near the tracker so many pairs fall inside the gate
	function automatic pair_item_t rand_score();
		logic [4:0]  tc, mc;
		int          g, reach, dx, dy;
		logic [31:0] tx, ty;
		logic [23:0] lo, hi, area;
		tc = 5'($urandom); mc = 5'($urandom);
		g  = int'(sb.rule_tab[{tc, mc}][GATE_W-1:0]);
		reach = (g == 0) ? 64 : g + g / 4;
		dx = $urandom_range(0, reach); dy = $urandom_range(0, reach);
		if ($urandom_range(0, 1)) dx = -dx;
		if ($urandom_range(0, 1)) dy = -dy;
		lo = sb.bound_tab[{tc, mc}][47:24];
		hi = sb.bound_tab[{tc, mc}][23:0];
		area = (lo <= hi && $urandom_range(0, 5) != 0) ? 24'($urandom_range(lo, hi))
			: 24'($urandom);
		tx = $urandom; ty = $urandom;
		if ($urandom_range(0, 9) == 0)
			return score_item(tc, mc, tx, ty, $urandom, $urandom, area);
		return score_item(tc, mc, tx, ty, tx + dx, ty + dy, area);
	endfunction

	initial begin
		sb = new();
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
		burst_left = 0; n_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Load the whole table before any scoring
		for (int i = 0; i < NENT; i++)
			send_item(rand_entry(5'(i >> 5), 5'(i)));

		// Directed: barred, zero gate, gate reached, min above max, area edges, extremes
		send_item(write_item(5'd0, 5'd0, 1'b0, 16'd100, 24'd0, 24'hFFFFFF));
		send_item(write_item(5'd0, 5'd1, 1'b1, 16'd0, 24'd0, 24'hFFFFFF));
		send_item(write_item(5'd0, 5'd2, 1'b1, 16'd500, 24'd10, 24'd20));
		send_item(write_item(5'd0, 5'd3, 1'b1, 16'd500, 24'd20, 24'd10));
		send_item(write_item(5'd31, 5'd31, 1'b1, 16'hFFFF, 24'd0, 24'hFFFFFF));
		send_item(score_item(5'd0, 5'd0, 0, 0, 0, 0, 24'd5));
		send_item(score_item(5'd0, 5'd1, 0, 0, 0, 0, 24'd5));
		send_item(score_item(5'd0, 5'd2, 0, 0, 500, 0, 24'd15));
		send_item(score_item(5'd0, 5'd2, 0, 0, 501, 0, 24'd15));
		send_item(score_item(5'd0, 5'd2, 0, 0, 300, 400, 24'd15));
		send_item(score_item(5'd0, 5'd2, 7, -7, 7, -7, 24'd10));
		send_item(score_item(5'd0, 5'd2, 7, -7, 7, -7, 24'd20));
		send_item(score_item(5'd0, 5'd2, 7, -7, 7, -7, 24'd9));
		send_item(score_item(5'd0, 5'd2, 7, -7, 7, -7, 24'd21));
		send_item(score_item(5'd0, 5'd3, 0, 0, 0, 0, 24'd15));
		send_item(score_item(5'd31, 5'd31, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 32'h7FFFFFFF, 24'hFFFFFF));
		send_item(score_item(5'd31, 5'd31, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF - 65535, 32'h80000000, 24'd0));
		send_item(score_item(5'd31, 5'd31, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF - 46340, 32'hFFFFFFFF - 46340, 24'hFFFFFF));
		send_item(score_item(5'd31, 5'd31, 0, 0, 0, 0, 24'd0));

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if ($urandom_range(0, 99) < 15)
				send_item(rand_entry(5'($urandom), 5'($urandom)));
			else
				send_item(rand_score());
		end
		s_tvalid = 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d items, checked %0d results: %0d scored, %0d barred, %0d gated,",
			n_sent, sb.n_checked, sb.n_status[0], sb.n_status[1], sb.n_status[2]);
		$display("%0d area out, %0d table writes.", sb.n_status[3], sb.n_status[4]);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[track_measurement_gating_score_unit] OK");
		else
			$display("[track_measurement_gating_score_unit] ERROR");
		$finish;
	end

	// Receiver: alternate between always ready, random stalls and a fixed pattern
	initial begin
		int phase, left, k;
		phase = 0; left = 0; k = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				phase = $urandom_range(0, 2);
				left  = $urandom_range(20, 200);
			end
			left--;
			k++;
			case (phase)
				0: m_tready = 1'b1;
				1: m_tready = $urandom_range(0, 2) != 0;
				default: m_tready = (k % 7) < 4;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[SCORE_W-1:0], m_tuser);
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", idle_cycles);
			$display("[track_measurement_gating_score_unit] ERROR");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule

[filelist.f]
+incdir+rtl
rtl/tmgs_pkg.sv
rtl/tmgs_ram.sv
rtl/tmgs_front.sv
rtl/tmgs_queue.sv
rtl/tmgs_back.sv
rtl/track_measurement_gating_score_unit.sv
verif/track_measurement_gating_score_unit_tb.sv
